// ===== hw/rtl/bytecode_instruction_decoder_core_assert.svh =====
// assertion macros for the bytecode instruction decoder
`ifndef BYTECODE_INSTRUCTION_DECODER_CORE_ASSERT_SVH
`define BYTECODE_INSTRUCTION_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BID_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define BID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bid_pkg.sv =====
// shared types and constants of the bytecode instruction decoder
`timescale 1ns / 1ps

package bid_pkg;

    localparam int DEFAULT_MAX_CODE_BYTES = 65536;

    localparam int IDX_W   = 17;
    localparam int START_W = 16;
    localparam int BYTE_W  = 8;
    localparam int ARG_W   = 32;
    localparam int HALF_W  = 16;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [IDX_W-1:0]  CODE_LENGTH_RST   = '0;
    localparam logic [BYTE_W-1:0] ARG_THRESHOLD_RST = 8'd90;
    localparam logic [BYTE_W-1:0] EXTEND_OPCODE_RST = 8'd143;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ARG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXTEND_OPCODE = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] STATUS_OK         = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_ARG_END    = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_PFX_END    = 2'd2;
    localparam logic [STAT_W-1:0] STATUS_PFX_NO_ARG = 2'd3;

    typedef enum logic [2:0] {
        PH_OPCODE   = 3'd0,
        PH_ARG_LO   = 3'd1,
        PH_ARG_HI   = 3'd2,
        PH_PFX_LO   = 3'd3,
        PH_PFX_HI   = 3'd4,
        PH_INNER    = 3'd5,
        PH_INNER_LO = 3'd6,
        PH_INNER_HI = 3'd7
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] code_byte;
        logic              string_start;
    } in_item_t;

    typedef struct packed {
        logic [START_W-1:0] instr_start;
        logic [BYTE_W-1:0]  opcode_value;
        logic [ARG_W-1:0]   argument;
        logic [IDX_W-1:0]   next_start;
        logic [STAT_W-1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [IDX_W-1:0]  code_length;
        logic [BYTE_W-1:0] arg_threshold;
        logic [BYTE_W-1:0] extend_opcode;
    } cfg_t;

    typedef struct packed {
        logic   halted;
        phase_t phase;
    } dec_stat_t;

endpackage

// ===== hw/rtl/bid_decode.sv =====
// byte-wise decode state machine: phase, index and argument state
`timescale 1ns / 1ps

module bid_decode #(
    parameter int MAX_CODE_BYTES = bid_pkg::DEFAULT_MAX_CODE_BYTES
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  bid_pkg::in_item_t   item,
    input  bid_pkg::cfg_t       cfg,
    output logic                res_valid,
    output bid_pkg::out_item_t  res,
    output bid_pkg::dec_stat_t  stat
);
    import bid_pkg::*;

    // compare width: holds index plus five and the clamp limit
    localparam int LIM_W = $clog2(MAX_CODE_BYTES + 1);
    localparam int CMP_W = (LIM_W > IDX_W + 1) ? LIM_W : IDX_W + 1;

    phase_t            phase_reg, phase_next, phase_eff;
    logic [IDX_W-1:0]  byte_index_reg, byte_index_next, idx;
    logic [BYTE_W-1:0] held_opcode_reg, held_opcode_next;
    logic [ARG_W-1:0]  arg_accum_reg, arg_accum_next;
    logic [IDX_W-1:0]  start_index_reg, start_index_next;
    logic              halted_reg, halted_next, halted_eff;

    logic [CMP_W-1:0]  len_raw, len_max, len_eff, idx_ext;
    logic [BYTE_W-1:0] b;
    logic              thr_hit, is_ext, at_end, arg_end, pfx_end;
    logic              advance;

    assign b          = item.code_byte;
    assign idx        = item.string_start ? '0 : byte_index_reg;
    assign phase_eff  = item.string_start ? PH_OPCODE : phase_reg;
    assign halted_eff = item.string_start ? 1'b0 : halted_reg;

    assign len_raw = CMP_W'(cfg.code_length);
    assign len_max = CMP_W'(MAX_CODE_BYTES);
    assign len_eff = (len_raw > len_max) ? len_max : len_raw;
    assign idx_ext = CMP_W'(idx);

    assign thr_hit = (b >= cfg.arg_threshold);
    assign is_ext  = (b == cfg.extend_opcode);
    assign at_end  = (idx_ext >= len_eff);
    assign arg_end = (idx_ext + CMP_W'(2) >= len_eff);
    assign pfx_end = (idx_ext + CMP_W'(5) >= len_eff);

    // next phase
    always_comb
    begin
        phase_next = phase_eff;
        if (!halted_eff)
        begin
            case (phase_eff)
                PH_OPCODE:
                begin
                    if (!at_end && thr_hit && !arg_end)
                        phase_next = is_ext ? (pfx_end ? PH_OPCODE : PH_PFX_LO) : PH_ARG_LO;
                    else
                        phase_next = PH_OPCODE;
                end
                PH_ARG_LO:   phase_next = PH_ARG_HI;
                PH_ARG_HI:   phase_next = PH_OPCODE;
                PH_PFX_LO:   phase_next = PH_PFX_HI;
                PH_PFX_HI:   phase_next = PH_INNER;
                PH_INNER:    phase_next = thr_hit ? PH_INNER_LO : PH_OPCODE;
                PH_INNER_LO: phase_next = PH_INNER_HI;
                PH_INNER_HI: phase_next = PH_OPCODE;
                default:     phase_next = PH_OPCODE;
            endcase
        end
    end

    // datapath and result
    always_comb
    begin
        held_opcode_next = held_opcode_reg;
        arg_accum_next   = arg_accum_reg;
        start_index_next = start_index_reg;
        halted_next      = halted_eff;
        advance          = !halted_eff;
        res_valid        = 1'b0;
        res.opcode_value = b;
        res.argument     = '0;
        res.next_start   = idx + IDX_W'(1);
        res.status       = STATUS_OK;
        if (!halted_eff)
        begin
            case (phase_eff)
                PH_OPCODE:
                begin
                    if (at_end)
                        advance = 1'b0;
                    else
                    begin
                        start_index_next = idx;
                        if (!thr_hit)
                            res_valid = 1'b1;
                        else if (arg_end)
                        begin
                            res_valid   = 1'b1;
                            res.status  = STATUS_ARG_END;
                            halted_next = 1'b1;
                        end
                        else if (is_ext)
                        begin
                            if (pfx_end)
                            begin
                                res_valid      = 1'b1;
                                res.status     = STATUS_PFX_END;
                                res.next_start = idx + IDX_W'(3);
                                halted_next    = 1'b1;
                            end
                        end
                        else
                            held_opcode_next = b;
                    end
                end
                PH_ARG_LO, PH_PFX_LO:
                    arg_accum_next = ARG_W'(b);
                PH_ARG_HI, PH_INNER_HI:
                begin
                    arg_accum_next   = arg_accum_reg | (ARG_W'(b) << BYTE_W);
                    res_valid        = 1'b1;
                    res.opcode_value = held_opcode_reg;
                    res.argument     = arg_accum_next;
                end
                PH_PFX_HI:
                    arg_accum_next = arg_accum_reg | (ARG_W'(b) << BYTE_W);
                PH_INNER:
                begin
                    if (!thr_hit)
                    begin
                        res_valid      = 1'b1;
                        res.status     = STATUS_PFX_NO_ARG;
                        res.next_start = start_index_reg + IDX_W'(3);
                        halted_next    = 1'b1;
                    end
                    else
                    begin
                        held_opcode_next = b;
                        arg_accum_next   = arg_accum_reg << HALF_W;
                    end
                end
                PH_INNER_LO:
                    arg_accum_next = arg_accum_reg | ARG_W'(b);
                default:
                    arg_accum_next = arg_accum_reg;
            endcase
        end
        if (halted_next)
            advance = 1'b0;
        byte_index_next = advance ? idx + IDX_W'(1) : idx;
        res.instr_start = start_index_next[START_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_OPCODE;
            byte_index_reg  <= '0;
            held_opcode_reg <= '0;
            arg_accum_reg   <= '0;
            start_index_reg <= '0;
            halted_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg       <= phase_next;
            byte_index_reg  <= byte_index_next;
            held_opcode_reg <= held_opcode_next;
            arg_accum_reg   <= arg_accum_next;
            start_index_reg <= start_index_next;
            halted_reg      <= halted_next;
        end
    end

    assign stat.halted = halted_reg;
    assign stat.phase  = phase_reg;

endmodule

// ===== hw/rtl/bid_obuf.sv =====
// result register with a skid stage behind it
`timescale 1ns / 1ps

module bid_obuf (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  bid_pkg::out_item_t  push_data,
    output logic                push_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output bid_pkg::out_item_t  out_data,
    output logic                skid_full
);
    import bid_pkg::*;

    logic      out_valid_reg, skid_valid_reg;
    out_item_t out_data_reg, skid_data_reg;
    logic      out_free;

    assign out_free   = !out_valid_reg || out_ready;
    assign push_ready = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= skid_valid_reg && push;
        end
        else if (push)
            skid_valid_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg  <= skid_valid_reg ? skid_data_reg : push_data;
            skid_data_reg <= push_data;
        end
        else if (push)
            skid_data_reg <= push_data;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign skid_full = skid_valid_reg;

endmodule

// ===== hw/rtl/bytecode_instruction_decoder_core.sv =====
// top level of the bytecode instruction decoder
`timescale 1ns / 1ps

// bytecode instruction decoder
// - in channel: one code byte per transfer, string_start marks the first byte of
//   a code string and restarts the index, the phase and the error halt
// - out channel: one decoded instruction (start, opcode, argument, next index,
//   status) per completed instruction or per error; nothing while halted
// - cfg channel: always ready, index 0 code length, 1 argument threshold,
//   2 extended-argument opcode; write only while the block is idle
// - throughput: one byte per cycle while in_ready is high; the decode state
//   machine updates in the cycle of the transfer and the result lands in the
//   output register that drives out, or in the skid stage while out is held
// - stall: a two-entry buffer (output register plus skid stage) sits in front of
//   out, so bytes keep flowing while one result waits; in_ready drops only when
//   both entries hold results
// - reset: decoder returns to the opcode phase at index 0, code length 0,
//   threshold 90, prefix opcode 143, buffers empty
module bytecode_instruction_decoder_core #(
    parameter int MAX_CODE_BYTES = bid_pkg::DEFAULT_MAX_CODE_BYTES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bid_pkg::in_item_t                 in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bid_pkg::out_item_t                out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bid_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bid_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bid_pkg::*;

    `include "bytecode_instruction_decoder_core_assert.svh"

    cfg_t      cfg_reg;
    logic      in_accept;
    logic      dec_valid;
    out_item_t dec_item;
    dec_stat_t dec_stat;
    logic      skid_full;

    // configuration registers, writes always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.code_length   <= CODE_LENGTH_RST;
            cfg_reg.arg_threshold <= ARG_THRESHOLD_RST;
            cfg_reg.extend_opcode <= EXTEND_OPCODE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_CODE_LENGTH:   cfg_reg.code_length   <= cfg_data[IDX_W-1:0];
                CFG_ARG_THRESHOLD: cfg_reg.arg_threshold <= cfg_data[BYTE_W-1:0];
                CFG_EXTEND_OPCODE: cfg_reg.extend_opcode <= cfg_data[BYTE_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    // byte transfer happens when in_valid is high and the skid stage has room
    assign in_accept = in_valid && in_ready;

    bid_decode #(
        .MAX_CODE_BYTES(MAX_CODE_BYTES)
    ) u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (in_accept),
        .item      (in_data),
        .cfg       (cfg_reg),
        .res_valid (dec_valid),
        .res       (dec_item),
        .stat      (dec_stat)
    );

    // result only pushed on a real byte transfer
    bid_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_accept && dec_valid),
        .push_data  (dec_item),
        .push_ready (in_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .skid_full  (skid_full)
    );

    // skid stage only fills behind a held output
    `BID_ASSERT_IMPL(a_skid_behind_out, clk, rst_n, skid_full, out_valid, "skid full, output empty")

    // an error result halts the decoder
    `BID_ASSERT_NEXT(a_err_halts, clk, rst_n, in_accept && dec_valid && dec_item.status != STATUS_OK, dec_stat.halted, "error result without halt")

    // error results carry a zero argument
    `BID_ASSERT_IMPL(a_err_zero_arg, clk, rst_n, dec_valid && dec_item.status != STATUS_OK, dec_item.argument == '0, "error result with argument")

    // a halted decoder always sits in the opcode phase
    `BID_ASSERT_IMPL(a_halt_phase, clk, rst_n, dec_stat.halted, dec_stat.phase == PH_OPCODE, "halted outside opcode phase")

endmodule
